// File: rtl/iftm_pkg.sv
// Package: payload types, state codes and register indexes of the field trace matcher.
`default_nettype none
package iftm_pkg;

  typedef struct packed {
    logic        op;
    logic [5:0]  entry_index;
    logic [3:0]  msg_command;
    logic [7:0]  msg_monitor;
    logic        msg_frame_start;
    logic [3:0]  msg_port;
    logic [15:0] msg_sequence;
    logic [49:0] msg_time_high;
    logic [15:0] msg_time_low;
    logic [63:0] sof_tsc;
    logic [63:0] tsc_anchor;
    logic [63:0] trace_anchor;
  } in_t;

  typedef struct packed {
    logic       field_top;
    logic       matched;
    logic [5:0] next_start;
  } out_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_MUL,
    ST_DIV,
    ST_CALC,
    ST_SCAN,
    ST_DONE
  } state_t;

  localparam logic OP_STORE = 1'b0;
  localparam logic OP_QUERY = 1'b1;

  localparam logic [2:0] REG_ISYS_100K = 3'd0;
  localparam logic [2:0] REG_TSC_100K  = 3'd1;
  localparam logic [2:0] REG_ISYS_MHZ  = 3'd2;
  localparam logic [2:0] REG_COMMAND   = 3'd3;
  localparam logic [2:0] REG_MONITOR   = 3'd4;
  localparam logic [2:0] REG_PORT      = 3'd5;
  localparam logic [2:0] REG_MAX_SHIFT = 3'd6;

  localparam int TAG_W  = 18;
  localparam int TIME_W = 64;
  localparam int CFG_W  = 16;

endpackage
`default_nettype wire

// File: rtl/interlace_field_trace_matcher_unit.sv
// Top level: trace message ring with interlaced field search.
//
// Input channel in_valid/in_stall/in_data carries store and query beats.
// A store beat writes one ring slot in the accept cycle and gives no result.
// A query beat scales the SOF time with one 16x16 multiplier and one radix-2
// divider, for two operands, then walks the ring memory one entry per cycle
// with a registered read. Query time is set by the shared divider and the
// ring memory read port. One item is in flight at a time.
// Output channel out_valid/out_stall/out_data carries one beat per query from
// an output register; a held result does not block a new input beat, but a
// finished query waits until that register frees up.
// Synchronous reset clears the control state, the search start index, the
// per-slot valid bits (unwritten slots read as zero) and loads the register
// reset values. Configuration is written via cfg_we/cfg_index/cfg_data.
`default_nettype none
module interlace_field_trace_matcher_unit #(
  parameter int RING_DEPTH = 64
) (
  input  wire logic              clk,
  input  wire logic              rst,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire iftm_pkg::in_t     in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output iftm_pkg::out_t         out_data,
  input  wire logic              cfg_we,
  input  wire logic [2:0]        cfg_index,
  input  wire logic [15:0]       cfg_data
);
  import iftm_pkg::*;

  localparam int IW = (RING_DEPTH > 2) ? $clog2(RING_DEPTH) : 1;

  logic [15:0] isys_100k, tsc_100k, max_shift;
  logic [11:0] isys_mhz;
  logic [3:0]  want_cmd, want_port;
  logic [7:0]  want_mon;

  state_t state, state_next;

  logic [TIME_W-1:0] times [RING_DEPTH];
  logic [TAG_W-1:0]  tags  [RING_DEPTH];
  logic [RING_DEPTH-1:0] slot_valid;

  logic [63:0] sof_r, base_r, tunit_r, acc, dvd, q_sof, sof_t;
  logic [15:0] rem;
  logic [5:0]  div_cnt;
  logic [1:0]  mul_j;
  logic        op_sel;
  logic [27:0] limit;
  logic [IW-1:0] start, rd_idx, idx_q;
  logic [IW:0]   issue_cnt, cmp_cnt;
  logic        rd_pend, vld_q;
  logic [TIME_W-1:0] time_q;
  logic [TAG_W-1:0]  tag_q;
  logic        found, top;
  logic [IW-1:0] found_next;

  logic in_acc, is_store, slot_ok, do_read, out_free;
  logic [IW+5:0] slot_ext, start_ext;
  logic [IW-1:0] slot;
  logic [63:0] hi, upper, new_time;
  logic [31:0] prod;
  logic [63:0] acc_new;
  logic [16:0] trial;
  logic        qbit;
  logic [15:0] tdiv;
  logic [11:0] mdiv;
  logic [63:0] ent_time, gap;
  logic [TAG_W-1:0] ent_tag;
  logic [16:0] want;
  logic hit, scan_end;
  logic [IW-1:0] idx_q_inc;

  function automatic logic [15:0] acc_chunk(input logic [63:0] v, input logic [1:0] j);
    logic [15:0] r;
    case (j)
      2'd0:    r = v[15:0];
      2'd1:    r = v[31:16];
      2'd2:    r = v[47:32];
      default: r = v[63:48];
    endcase
    return r;
  endfunction

  assign in_acc   = in_valid && !in_stall;
  assign is_store = in_data.op == OP_STORE;
  assign slot_ext = {{IW{1'b0}}, in_data.entry_index};
  assign slot     = slot_ext[IW-1:0];
  assign slot_ok  = 32'(in_data.entry_index) < 32'(RING_DEPTH);
  assign out_free = !out_valid || !out_stall;

  assign hi       = {in_data.msg_time_high, 14'b0};
  assign upper    = {hi[63:16], 16'b0};
  assign new_time = (hi[15:14] >= in_data.msg_time_low[15:14]) ?
                    (upper | 64'(in_data.msg_time_low)) :
                    ((upper - 64'h10000) | 64'(in_data.msg_time_low));

  assign tdiv = (tsc_100k == '0) ? 16'd1 : tsc_100k;
  assign mdiv = (isys_mhz == '0) ? 12'd1 : isys_mhz;

  assign prod    = 32'(acc_chunk(op_sel ? base_r : sof_r, mul_j)) * 32'(isys_100k);
  assign acc_new = acc + (64'(prod) << {mul_j, 4'b0});

  assign trial = {rem, dvd[63]};
  assign qbit  = trial >= {1'b0, tdiv};

  assign ent_time  = vld_q ? time_q : '0;
  assign ent_tag   = vld_q ? tag_q : '0;
  assign gap       = (sof_t > ent_time) ? sof_t - ent_time : ent_time - sof_t;
  assign want      = {want_port, 1'b1, want_mon, want_cmd};
  assign hit       = rd_pend && (ent_tag[16:0] == want) && (gap < 64'(limit));
  assign scan_end  = rd_pend && (hit || cmp_cnt == (IW+1)'(RING_DEPTH - 1));
  assign idx_q_inc = (idx_q == IW'(RING_DEPTH - 1)) ? '0 : idx_q + 1'b1;
  assign start_ext = {6'b0, found_next};

  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: if (in_acc && !is_store) state_next = ST_MUL;
      ST_MUL:  if (mul_j == 2'd3) state_next = ST_DIV;
      ST_DIV:  if (div_cnt == 6'd63) state_next = op_sel ? ST_CALC : ST_MUL;
      ST_CALC: state_next = ST_SCAN;
      ST_SCAN: if (scan_end) state_next = ST_DONE;
      ST_DONE: if (out_free) state_next = ST_IDLE;
      default: state_next = ST_IDLE;
    endcase
  end

  always_comb begin
    in_stall = state != ST_IDLE;
    do_read  = (state == ST_SCAN) && (issue_cnt < (IW+1)'(RING_DEPTH)) && !scan_end;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      isys_100k <= 16'd4000;
      tsc_100k  <= 16'd192;
      isys_mhz  <= 12'd400;
      want_cmd  <= '0;
      want_mon  <= '0;
      want_port <= '0;
      max_shift <= 16'd100;
      slot_valid <= '0;
      start     <= '0;
      out_valid <= 1'b0;
      rd_pend   <= 1'b0;
    end else begin
      state <= state_next;
      if (cfg_we) begin
        case (cfg_index)
          REG_ISYS_100K: isys_100k <= cfg_data;
          REG_TSC_100K:  tsc_100k  <= cfg_data;
          REG_ISYS_MHZ:  isys_mhz  <= cfg_data[11:0];
          REG_COMMAND:   want_cmd  <= cfg_data[3:0];
          REG_MONITOR:   want_mon  <= cfg_data[7:0];
          REG_PORT:      want_port <= cfg_data[3:0];
          REG_MAX_SHIFT: max_shift <= cfg_data;
          default: ;
        endcase
      end
      if (in_acc && is_store && slot_ok) slot_valid[slot] <= 1'b1;
      if (state == ST_DONE && out_free) begin
        out_valid <= 1'b1;
        if (found) start <= found_next;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      rd_pend <= do_read;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc && is_store && slot_ok) begin
      times[slot] <= new_time;
      tags[slot]  <= {in_data.msg_sequence[0], in_data.msg_port,
                      in_data.msg_frame_start, in_data.msg_monitor, in_data.msg_command};
    end
    if (do_read) begin
      time_q <= times[rd_idx];
      tag_q  <= tags[rd_idx];
      vld_q  <= slot_valid[rd_idx];
      idx_q  <= rd_idx;
    end
  end

  always_ff @(posedge clk) begin
    case (state)
      ST_IDLE: begin
        sof_r   <= in_data.sof_tsc;
        base_r  <= in_data.tsc_anchor;
        tunit_r <= in_data.trace_anchor;
        acc     <= '0;
        mul_j   <= '0;
        op_sel  <= 1'b0;
      end
      ST_MUL: begin
        acc   <= acc_new;
        mul_j <= mul_j + 1'b1;
        if (mul_j == 2'd3) begin
          dvd     <= acc_new;
          rem     <= '0;
          div_cnt <= '0;
        end
      end
      ST_DIV: begin
        rem     <= qbit ? 16'(trial - {1'b0, tdiv}) : trial[15:0];
        dvd     <= {dvd[62:0], qbit};
        div_cnt <= div_cnt + 1'b1;
        if (div_cnt == 6'd63) begin
          acc   <= '0;
          mul_j <= '0;
          if (!op_sel) q_sof <= {dvd[62:0], qbit};
          op_sel <= 1'b1;
        end
      end
      ST_CALC: begin
        sof_t     <= tunit_r + q_sof - dvd;
        limit     <= 28'(max_shift) * 28'(mdiv);
        rd_idx    <= start;
        issue_cnt <= '0;
        cmp_cnt   <= '0;
        found     <= 1'b0;
        top       <= 1'b1;
        found_next <= start;
      end
      ST_SCAN: begin
        if (do_read) begin
          rd_idx    <= (rd_idx == IW'(RING_DEPTH - 1)) ? '0 : rd_idx + 1'b1;
          issue_cnt <= issue_cnt + 1'b1;
        end
        if (rd_pend) cmp_cnt <= cmp_cnt + 1'b1;
        if (hit) begin
          found      <= 1'b1;
          top        <= ent_tag[17];
          found_next <= idx_q_inc;
        end
      end
      ST_DONE: begin
        if (out_free) begin
          out_data.field_top  <= top;
          out_data.matched    <= found;
          out_data.next_start <= start_ext[5:0];
        end
      end
      default: ;
    endcase
  end

  a_out_from_done: assert property (@(posedge clk) disable iff (rst)
    $rose(out_valid) |-> $past(state == ST_DONE))
    else $error("result beat without finished query");

  a_nomatch_top: assert property (@(posedge clk) disable iff (rst)
    (out_valid && !out_data.matched) |-> out_data.field_top)
    else $error("unmatched query reported bottom field");

  a_scan_bound: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |-> (cmp_cnt < (IW+1)'(RING_DEPTH)))
    else $error("ring walk overran depth");

  a_stall_busy: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCAN) |=> (state == ST_SCAN || state == ST_DONE))
    else $error("scan left without finishing");

endmodule
`default_nettype wire
